FILE: rtl/stack_push_pop_frame_engine_core_assert.svh
// Assertion macros for the stack engine checker
`ifndef STACK_PUSH_POP_FRAME_ENGINE_CORE_ASSERT_SVH
`define STACK_PUSH_POP_FRAME_ENGINE_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent
`define SPPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define SPPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sppf_pkg.sv
// Types, mode codes and helpers for the stack push/pop/frame engine
`default_nettype none
package sppf_pkg;

  // Operation codes carried in the mode field
  localparam logic [3:0] MODE_PUSH16  = 4'd0;
  localparam logic [3:0] MODE_PUSH32  = 4'd1;
  localparam logic [3:0] MODE_PUSHSEG = 4'd2;
  localparam logic [3:0] MODE_POP16   = 4'd3;
  localparam logic [3:0] MODE_POP32   = 4'd4;
  localparam logic [3:0] MODE_ENTER16 = 4'd5;
  localparam logic [3:0] MODE_ENTER32 = 4'd6;
  localparam logic [3:0] MODE_LEAVE16 = 4'd7;
  localparam logic [3:0] MODE_LEAVE32 = 4'd8;
  localparam logic [3:0] MODE_SETSP   = 4'd9;
  localparam logic [3:0] MODE_SETBP   = 4'd10;

  localparam logic [31:0] LOW16_MASK = 32'h0000_ffff;
  localparam int LEVEL_BITS = 5;   // nesting level is taken mod 32
  localparam int LANES      = 4;   // byte lanes of the stack store
  localparam int LANE_BITS  = 2;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] value;
    logic [15:0] frame_size;
    logic [7:0]  nesting_level;
  } in_word_t;

  typedef struct packed {
    logic [31:0] popped_value;
    logic [31:0] stack_pointer;
    logic [31:0] base_pointer;
  } out_word_t;

  // One access to the byte-lane store
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic        wrap16;   // offsets wrap at 64K
    logic        four;     // 4 bytes, else 2
    logic [31:0] addr;     // first byte offset, already wrapped
    logic [31:0] wdata;
  } mem_req_t;

  // Stack offset seen through the current stack size
  function automatic logic [31:0] wrap_off(input logic wrap16, input logic [31:0] x);
    wrap_off = wrap16 ? (x & LOW16_MASK) : x;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sppf_ram.sv
// Generic single-clock RAM, one write port, one registered read port
`default_nettype none
module sppf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sppf_mem.sv
// Little-endian stack store split over four byte lanes, 2 or 4 bytes a cycle
`default_nettype none
module sppf_mem import sppf_pkg::*; #(
  parameter int ADDR_BITS = 12
) (
  input  wire logic        clk,
  input  wire mem_req_t    req,
  output logic      [31:0] rdata
);

  localparam int ROW_BITS = ADDR_BITS - LANE_BITS;
  localparam int DEPTH    = 1 << ROW_BITS;

  logic [7:0]           lane_q [LANES];
  logic [LANE_BITS-1:0] off_r;

  // Each lane holds byte i of the access, where i = lane - start offset
  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [LANE_BITS-1:0] idx;
    logic [31:0]          byte_addr;
    logic                 we;
    logic [7:0]           wbyte;

    assign idx       = LANE_BITS'(b) - req.addr[LANE_BITS-1:0];
    assign byte_addr = wrap_off(req.wrap16, req.addr + {30'b0, idx});
    assign we        = req.wr && (req.four || !idx[1]);
    assign wbyte     = 8'(req.wdata >> {idx, 3'b000});

    sppf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (byte_addr[ADDR_BITS-1:LANE_BITS]),
      .wdata (wbyte),
      .re    (req.rd),
      .raddr (byte_addr[ADDR_BITS-1:LANE_BITS]),
      .rdata (lane_q[b])
    );
  end

  // Start offset of the read in flight, to rotate lanes back into order
  always_ff @(posedge clk) begin
    if (req.rd) begin
      off_r <= req.addr[LANE_BITS-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rdata[8*i +: 8] = lane_q[LANE_BITS'(i) + off_r];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stack_push_pop_frame_engine_core.sv
// Stack engine top: push, pop, ENTER, LEAVE and pointer loads over a byte store
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------------
//   input   | start, busy, in_data           | taken when start && !busy
//   result  | out_valid, out_data            | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_data | write when valid && ready
//
// Push, pointer loads, unused modes and ENTER at level 0 are done in ST_IDLE;
// pop and LEAVE pass ST_POP (read, then data back); ENTER at level L > 0 runs
// ST_ERD, ST_EWR per copied frame pointer (a store read, a store write), then
// ST_EFRM. The registered result word comes in the cycle after the last one.
// The store has a single access per cycle. Reset is synchronous and clears
// the pointers, the stack mode and the sequencer; the store is not cleared.
`default_nettype none
module stack_push_pop_frame_engine_core import sppf_pkg::*; #(
  parameter int STACK_ADDR_BITS = 12
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  output out_word_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_POP  = 5'b00010,
    ST_ERD  = 5'b00100,
    ST_EWR  = 5'b01000,
    ST_EFRM = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  cfg16_r, cfg16_nxt;
  logic [31:0]           sp_r, sp_nxt;
  logic [31:0]           bp_r, bp_nxt;
  logic                  four_r, four_nxt;
  logic                  leave_r, leave_nxt;
  logic [31:0]           walk_r, walk_nxt;
  logic [31:0]           frame_r, frame_nxt;
  logic [15:0]           size_r, size_nxt;
  logic [LEVEL_BITS-1:0] level_r, level_nxt;
  logic [LEVEL_BITS-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;

  mem_req_t    req;
  logic [31:0] rdata;

  // Stack pointer update: 16-bit stacks only touch the low half
  function automatic logic [31:0] set_sp(input logic wrap16, input logic [31:0] old,
                                         input logic [31:0] v);
    set_sp = wrap16 ? {old[31:16], v[15:0]} : v;
  endfunction

  // Base pointer update by operand size
  function automatic logic [31:0] set_bp(input logic four, input logic [31:0] old,
                                         input logic [31:0] v);
    set_bp = four ? v : {old[31:16], v[15:0]};
  endfunction

  sppf_mem #(.ADDR_BITS(STACK_ADDR_BITS)) u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer and pointer datapath
  always_comb begin
    logic        emit;
    logic [31:0] popped;
    logic [31:0] step_in;
    logic [31:0] step_r;
    logic [31:0] sp_dec;
    logic [31:0] sp_push;
    logic [31:0] frame;
    logic [31:0] walk;
    logic [LEVEL_BITS-1:0] lvl;
    logic        wide;

    state_nxt = state_r;
    cfg16_nxt = cfg16_r;
    sp_nxt    = sp_r;
    bp_nxt    = bp_r;
    four_nxt  = four_r;
    leave_nxt = leave_r;
    walk_nxt  = walk_r;
    frame_nxt = frame_r;
    size_nxt  = size_r;
    level_nxt = level_r;
    cnt_nxt   = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    emit   = 1'b0;
    popped = '0;
    req        = '0;
    req.wrap16 = cfg16_r;

    wide = (in_data.mode == MODE_PUSH32)   || (in_data.mode == MODE_PUSHSEG) ||
           (in_data.mode == MODE_POP32)    || (in_data.mode == MODE_ENTER32) ||
           (in_data.mode == MODE_LEAVE32);
    step_in = wide ? 32'd4 : 32'd2;
    step_r  = four_r ? 32'd4 : 32'd2;
    sp_dec  = '0;
    sp_push = '0;
    frame   = '0;
    walk    = '0;
    lvl     = in_data.nesting_level[LEVEL_BITS-1:0];

    if (cfg_valid && cfg_ready) begin
      cfg16_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.mode) inside
            MODE_PUSH16, MODE_PUSH32, MODE_PUSHSEG: begin
              sp_dec    = sp_r - step_in;
              req.wr    = 1'b1;
              req.addr  = wrap_off(cfg16_r, sp_dec);
              req.four  = (in_data.mode == MODE_PUSH32);
              req.wdata = in_data.value;
              sp_nxt    = set_sp(cfg16_r, sp_r, sp_dec);
              emit      = 1'b1;
            end
            MODE_POP16, MODE_POP32: begin
              req.rd    = 1'b1;
              req.addr  = wrap_off(cfg16_r, sp_r);
              four_nxt  = (in_data.mode == MODE_POP32);
              leave_nxt = 1'b0;
              state_nxt = ST_POP;
            end
            MODE_LEAVE16, MODE_LEAVE32: begin
              req.rd    = 1'b1;
              req.addr  = wrap_off(cfg16_r, bp_r);
              four_nxt  = (in_data.mode == MODE_LEAVE32);
              leave_nxt = 1'b1;
              state_nxt = ST_POP;
            end
            MODE_ENTER16, MODE_ENTER32: begin
              // push the old frame pointer
              sp_dec    = sp_r - step_in;
              req.wr    = 1'b1;
              req.addr  = wrap_off(cfg16_r, sp_dec);
              req.four  = wide;
              req.wdata = bp_r;
              sp_push   = set_sp(cfg16_r, sp_r, sp_dec);
              frame     = wide ? sp_push : (sp_push & LOW16_MASK);
              four_nxt  = wide;
              frame_nxt = frame;
              walk_nxt  = wrap_off(cfg16_r, bp_r);
              size_nxt  = in_data.frame_size;
              level_nxt = lvl;
              cnt_nxt   = LEVEL_BITS'(1);
              if (lvl == '0) begin
                sp_nxt = set_sp(cfg16_r, sp_r, sp_push - {16'b0, in_data.frame_size});
                bp_nxt = set_bp(wide, bp_r, frame);
                emit   = 1'b1;
              end else if (lvl == LEVEL_BITS'(1)) begin
                sp_nxt    = sp_push;
                state_nxt = ST_EFRM;
              end else begin
                sp_nxt    = sp_push;
                state_nxt = ST_ERD;
              end
            end
            MODE_SETSP: begin
              sp_nxt = in_data.value;
              emit   = 1'b1;
            end
            MODE_SETBP: begin
              bp_nxt = in_data.value;
              emit   = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      // store data is back for pop or LEAVE
      ST_POP: begin
        if (leave_r) begin
          walk   = wrap_off(cfg16_r, bp_r);
          sp_nxt = set_sp(cfg16_r, sp_r, walk + step_r);
          bp_nxt = set_bp(four_r, bp_r, rdata);
        end else begin
          popped = four_r ? rdata : (rdata & LOW16_MASK);
          sp_nxt = set_sp(cfg16_r, sp_r, sp_r + step_r);
        end
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end

      // read the next enclosing frame pointer
      ST_ERD: begin
        walk      = wrap_off(cfg16_r, walk_r - step_r);
        req.rd    = 1'b1;
        req.addr  = walk;
        walk_nxt  = walk;
        state_nxt = ST_EWR;
      end

      // push the frame pointer just read
      ST_EWR: begin
        sp_dec    = sp_r - step_r;
        req.wr    = 1'b1;
        req.addr  = wrap_off(cfg16_r, sp_dec);
        req.four  = four_r;
        req.wdata = rdata;
        sp_nxt    = set_sp(cfg16_r, sp_r, sp_dec);
        cnt_nxt   = cnt_r + LEVEL_BITS'(1);
        state_nxt = (cnt_nxt == level_r) ? ST_EFRM : ST_ERD;
      end

      // push the new frame pointer, set BP, reserve locals
      ST_EFRM: begin
        sp_dec    = sp_r - step_r;
        req.wr    = 1'b1;
        req.addr  = wrap_off(cfg16_r, sp_dec);
        req.four  = four_r;
        req.wdata = frame_r;
        sp_nxt    = set_sp(cfg16_r, sp_r, sp_dec - {16'b0, size_r});
        bp_nxt    = set_bp(four_r, bp_r, frame_r);
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.popped_value  = popped;
      out_data_nxt.stack_pointer = sp_nxt;
      out_data_nxt.base_pointer  = bp_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg16_r     <= 1'b0;
      sp_r        <= '0;
      bp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg16_r     <= cfg16_nxt;
      sp_r        <= sp_nxt;
      bp_r        <= bp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operation payload
  always_ff @(posedge clk) begin
    four_r     <= four_nxt;
    leave_r    <= leave_nxt;
    walk_r     <= walk_nxt;
    frame_r    <= frame_nxt;
    size_r     <= size_nxt;
    level_r    <= level_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/sppf_chk.sv
// Port-level checks for the stack engine, bound to the top level
`default_nettype none
`include "stack_push_pop_frame_engine_core_assert.svh"
module sppf_chk import sppf_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire out_word_t out_data
);

  logic acc;
  logic is_push;
  logic is_read;

  assign acc     = start && !busy;
  assign is_push = (in_data.mode == MODE_PUSH16) || (in_data.mode == MODE_PUSH32) ||
                   (in_data.mode == MODE_PUSHSEG);
  assign is_read = (in_data.mode == MODE_POP16) || (in_data.mode == MODE_POP32) ||
                   (in_data.mode == MODE_LEAVE16) || (in_data.mode == MODE_LEAVE32);

  `SPPF_ASSERT_NEXT(a_no_spurious, !busy && !start, !out_valid, "result word with no word taken")
  `SPPF_ASSERT_NOW(a_done_idle, out_valid, !busy, "result word while still busy")
  `SPPF_ASSERT_NEXT(a_push_one, acc && is_push, out_valid && !busy, "push did not finish in one cycle")
  `SPPF_ASSERT_NEXT(a_read_wait, acc && is_read, busy && !out_valid, "pop or leave skipped the store read")
  `SPPF_ASSERT_NEXT(a_setsp, acc && (in_data.mode == MODE_SETSP), out_valid && (out_data.stack_pointer == $past(in_data.value)), "stack pointer load lost")

endmodule

bind stack_push_pop_frame_engine_core sppf_chk u_sppf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the stack push/pop/frame engine core
module testbench;
  import sppf_pkg::*;

  localparam int ADDR_BITS = 12;
  localparam int STORE_BYTES = 1 << ADDR_BITS;
  localparam logic [31:0] STORE_MASK = STORE_BYTES - 1;
  localparam logic [3:0] MODE_TOP = 4'hf;  // largest code the mode field can carry
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_WORDS = 190;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_data = '0;
  logic out_valid;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  stack_push_pop_frame_engine_core #(.STACK_ADDR_BITS(ADDR_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the stack unit
  logic [31:0] sp_r = '0;
  logic [31:0] bp_r = '0;
  logic narrow_stack = 1'b0;
  logic [7:0] store_byte [STORE_BYTES];
  bit store_valid [STORE_BYTES];

  out_word_t pending_reports [$];
  out_word_t want;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_enters = 0;
  int deepest = 0;
  int n_redirects = 0;
  int n_mode_writes = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  // Offset as seen through the current stack size
  function automatic logic [31:0] stack_off(logic [31:0] x);
    return narrow_stack ? (x & LOW16_MASK) : x;
  endfunction

  function automatic int unsigned store_addr(logic [31:0] off, int unsigned i);
    return stack_off(off + i) & STORE_MASK;
  endfunction

  function automatic void store_put(logic [31:0] off, logic [31:0] val, int unsigned n);
    int unsigned a;
    for (int unsigned i = 0; i < n; i++) begin
      a = store_addr(off, i);
      store_byte[a] = val[8*i +: 8];
      store_valid[a] = 1'b1;
    end
  endfunction

  function automatic logic [31:0] store_get(logic [31:0] off, int unsigned n);
    logic [31:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++)
      v[8*i +: 8] = store_byte[store_addr(off, i)];
    return v;
  endfunction

  function automatic bit bytes_written(logic [31:0] off, int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      if (!store_valid[store_addr(off, i)]) return 1'b0;
    return 1'b1;
  endfunction

  // Narrow stack only moves the low half of SP
  function automatic void set_sp(logic [31:0] v);
    sp_r = narrow_stack ? {sp_r[31:16], v[15:0]} : v;
  endfunction

  function automatic void set_bp_sized(logic [31:0] v, int unsigned n);
    bp_r = (n == 2) ? {bp_r[31:16], v[15:0]} : v;
  endfunction

  function automatic void push_slot(logic [31:0] val, int unsigned slot, int unsigned n);
    store_put(stack_off(stack_off(sp_r) - slot), val, n);
    set_sp(sp_r - slot);
  endfunction

  function automatic logic [31:0] pop_bytes(int unsigned n);
    logic [31:0] v;
    v = store_get(stack_off(sp_r), n);
    set_sp(sp_r + n);
    return v;
  endfunction

  // ENTER: save BP, copy enclosing frame pointers, push new frame, reserve locals
  function automatic void enter_frame(int unsigned n, logic [15:0] size, logic [4:0] lvl);
    logic [31:0] opmask;
    logic [31:0] frame;
    logic [31:0] walk;
    opmask = (n == 2) ? LOW16_MASK : 32'hffff_ffff;
    push_slot(bp_r & opmask, n, n);
    frame = sp_r & opmask;
    if (lvl != 0) begin
      walk = stack_off(bp_r);
      for (int unsigned i = 1; i < lvl; i++) begin
        walk = stack_off(walk - n);
        push_slot(store_get(walk, n), n, n);
      end
      push_slot(frame, n, n);
    end
    set_bp_sized(frame, n);
    set_sp(sp_r - {16'd0, size});
  endfunction

  function automatic void leave_frame(int unsigned n);
    logic [31:0] b;
    logic [31:0] nb;
    b = stack_off(bp_r);
    nb = store_get(b, n);
    set_sp(b + n);
    set_bp_sized(nb, n);
  endfunction

  // Apply one operation to the shadow state and return the result word
  function automatic out_word_t perform_stack_op(in_word_t w);
    out_word_t r;
    r.popped_value = '0;
    case (w.mode)
      MODE_PUSH16:  push_slot(w.value & LOW16_MASK, 2, 2);
      MODE_PUSH32:  push_slot(w.value, 4, 4);
      MODE_PUSHSEG: push_slot(w.value & LOW16_MASK, 4, 2);
      MODE_POP16:   r.popped_value = pop_bytes(2);
      MODE_POP32:   r.popped_value = pop_bytes(4);
      MODE_ENTER16: enter_frame(2, w.frame_size, w.nesting_level[LEVEL_BITS-1:0]);
      MODE_ENTER32: enter_frame(4, w.frame_size, w.nesting_level[LEVEL_BITS-1:0]);
      MODE_LEAVE16: leave_frame(2);
      MODE_LEAVE32: leave_frame(4);
      MODE_SETSP:   sp_r = w.value;
      MODE_SETBP:   bp_r = w.value;
      default: ;
    endcase
    r.stack_pointer = sp_r;
    r.base_pointer = bp_r;
    return r;
  endfunction

  // True when every byte the operation reads was written before it starts
  function automatic bit reads_settled(in_word_t w);
    logic [31:0] walk;
    int unsigned n;
    int unsigned lvl;
    case (w.mode)
      MODE_POP16:   return bytes_written(stack_off(sp_r), 2);
      MODE_POP32:   return bytes_written(stack_off(sp_r), 4);
      MODE_LEAVE16: return bytes_written(stack_off(bp_r), 2);
      MODE_LEAVE32: return bytes_written(stack_off(bp_r), 4);
      MODE_ENTER16, MODE_ENTER32: begin
        n = (w.mode == MODE_ENTER16) ? 2 : 4;
        lvl = w.nesting_level[LEVEL_BITS-1:0];
        walk = stack_off(bp_r);
        for (int unsigned i = 1; i < lvl; i++) begin
          walk = stack_off(walk - n);
          if (!bytes_written(walk, n)) return 1'b0;
        end
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic in_word_t make_word(logic [3:0] op, logic [31:0] value,
                                         logic [15:0] size, logic [7:0] nest);
    in_word_t w;
    w.mode = op;
    w.value = value;
    w.frame_size = size;
    w.nesting_level = nest;
    return w;
  endfunction

  function automatic logic [3:0] pick_push();
    case ($urandom_range(0, 2))
      0: return MODE_PUSH16;
      1: return MODE_PUSH32;
      default: return MODE_PUSHSEG;
    endcase
  endfunction

  // Drive one word; called at a rising edge, returns at the edge that takes it
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    // a read of never-written bytes is turned into a push
    if (!reads_settled(w)) begin
      w.mode = MODE_PUSH32;
      n_redirects++;
    end
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_reports.push_back(perform_stack_op(w));
    n_items++;
    if (w.mode == MODE_ENTER16 || w.mode == MODE_ENTER32) begin
      n_enters++;
      if (w.nesting_level[LEVEL_BITS-1:0] > deepest)
        deepest = w.nesting_level[LEVEL_BITS-1:0];
    end
  endtask

  // Stop sending and wait for all pending results
  task automatic settle();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_stack_mode(input bit narrow);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= narrow;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    narrow_stack = narrow;
    cfg_valid <= 1'b0;
    n_mode_writes++;
  endtask

  // Result checker: sample mid-cycle, compare with the oldest pending word
  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result word %h with nothing pending", $time, out_data);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        n_results++;
        check_field("popped_value", want.popped_value, out_data.popped_value);
        check_field("stack_pointer", want.stack_pointer, out_data.stack_pointer);
        check_field("base_pointer", want.base_pointer, out_data.base_pointer);
      end
    end
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count,
               pending_reports.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Push/pop widths; segment push leaves the slot's upper bytes alone
  task automatic test_push_pop();
    send_word(make_word(MODE_PUSH32, 32'hffff_ffff, $urandom(), $urandom()));
    send_word(make_word(MODE_POP32, $urandom(), $urandom(), $urandom()));
    send_word(make_word(MODE_PUSHSEG, 32'h1234_0000, $urandom(), $urandom()));
    send_word(make_word(MODE_POP32, $urandom(), $urandom(), $urandom()));
    send_word(make_word(MODE_PUSH16, 32'ha5a5_8001, $urandom(), $urandom()));
    send_word(make_word(MODE_POP16, $urandom(), $urandom(), $urandom()));
  endtask

  // Direct loads at the extremes, then the unused codes
  task automatic test_pointer_loads();
    send_word(make_word(MODE_SETSP, 32'hffff_ffff, $urandom(), $urandom()));
    send_word(make_word(MODE_SETBP, 32'hffff_ffff, $urandom(), $urandom()));
    for (int m = int'(MODE_SETBP) + 1; m <= int'(MODE_TOP); m++)
      send_word(make_word(m, $urandom(), $urandom(), $urandom()));
  endtask

  // ENTER at level 0 with the largest frame, nested 16-bit frames, LEAVE
  task automatic test_frames();
    send_word(make_word(MODE_SETSP, 32'h0000_0800, $urandom(), $urandom()));
    send_word(make_word(MODE_SETBP, 32'h0000_0a00, $urandom(), $urandom()));
    send_word(make_word(MODE_ENTER32, $urandom(), 16'hffff, 8'h00));
    send_word(make_word(MODE_LEAVE32, $urandom(), $urandom(), $urandom()));
    send_word(make_word(MODE_ENTER16, $urandom(), 16'd2, 8'h01));
    // upper level bits are ignored: this is level 2
    send_word(make_word(MODE_ENTER16, $urandom(), 16'd0, 8'he2));
    send_word(make_word(MODE_LEAVE16, $urandom(), $urandom(), $urandom()));
    send_word(make_word(MODE_LEAVE16, $urandom(), $urandom(), $urandom()));
  endtask

  // 16-bit stack: accesses wrap at 64K, SP keeps its upper half
  task automatic test_narrow_stack();
    write_stack_mode(1'b1);
    send_word(make_word(MODE_SETSP, 32'habcd_0002, $urandom(), $urandom()));
    send_word(make_word(MODE_PUSH32, 32'h89ab_cdef, $urandom(), $urandom()));
    send_word(make_word(MODE_POP32, $urandom(), $urandom(), $urandom()));
    send_word(make_word(MODE_ENTER16, $urandom(), 16'd3, 8'h01));
    send_word(make_word(MODE_LEAVE16, $urandom(), $urandom(), $urandom()));
  endtask

  task automatic push_pop_burst();
    int unsigned k;
    k = $urandom_range(1, 8);
    repeat (k) send_word(make_word(pick_push(), $urandom(), $urandom(), $urandom()));
    repeat ($urandom_range(1, k))
      send_word(make_word($urandom_range(0, 1) ? MODE_POP32 : MODE_POP16,
                          $urandom(), $urandom(), $urandom()));
  endtask

  // Nested ENTERs with rising level, then as many LEAVEs
  task automatic frame_chain();
    bit wide;
    int unsigned first;
    int unsigned depth;
    logic [3:0] enter_op;
    logic [3:0] leave_op;
    logic [15:0] size;
    logic [7:0] nest;
    wide = $urandom_range(0, 1);
    enter_op = wide ? MODE_ENTER32 : MODE_ENTER16;
    leave_op = wide ? MODE_LEAVE32 : MODE_LEAVE16;
    first = ($urandom_range(0, 4) == 0) ? 0 : 1;
    depth = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 31) : $urandom_range(1, 4);
    for (int unsigned lvl = first; lvl <= depth; lvl++) begin
      size = $urandom();
      if ($urandom_range(0, 9) != 0) size = $urandom_range(0, 40);
      nest = $urandom();
      nest[LEVEL_BITS-1:0] = lvl;
      send_word(make_word(enter_op, $urandom(), size, nest));
      if ($urandom_range(0, 2) == 0)
        send_word(make_word(pick_push(), $urandom(), $urandom(), $urandom()));
    end
    for (int unsigned d = first; d <= depth; d++) begin
      if ($urandom_range(0, 7) == 0)
        send_word(make_word(wide ? MODE_LEAVE16 : MODE_LEAVE32,
                            $urandom(), $urandom(), $urandom()));
      else
        send_word(make_word(leave_op, $urandom(), $urandom(), $urandom()));
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4))
      send_word(make_word($urandom_range(0, int'(MODE_TOP)), $urandom(), $urandom(),
                          $urandom()));
  endtask

  // Move SP or BP: anywhere, near the 64K edge, inside the store, or to the current SP
  task automatic relocate();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: v = {16'($urandom()), 12'hfff, 4'($urandom())};
      2: v = (sp_r & ~STORE_MASK) | ($urandom() & STORE_MASK);
      default: v = sp_r;
    endcase
    send_word(make_word($urandom_range(0, 1) ? MODE_SETBP : MODE_SETSP, v, $urandom(),
                        $urandom()));
  endtask

  // Random traffic in phases, stack mode rewritten before each phase
  task automatic test_random_traffic();
    int phase_start;
    for (int ph = 0; ph < 6; ph++) begin
      write_stack_mode(ph < 2 ? (ph == 0) : $urandom_range(0, 1));
      phase_start = n_items;
      while (n_items - phase_start < PHASE_WORDS) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_pop_burst();
          4, 5, 6: frame_chain();
          7: noise_burst();
          default: relocate();
        endcase
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_push_pop();
    test_pointer_loads();
    test_frames();
    test_narrow_stack();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $display("%0d result words never arrived", pending_reports.size());
      errors++;
    end
    $display("ran %0d stack operations, %0d result words compared, %0d mismatches",
             n_items, n_results, errors);
    $display("%0d ENTERs up to nesting %0d, %0d stack mode writes, %0d reads redirected",
             n_enters, deepest, n_mode_writes, n_redirects);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
